// ----- rtl/core/calibrated_window_motion_detector_top_assert.svh -----
// assertion macros for the motion detector checker
// no dependencies; included by the checker file only
`ifndef CALIBRATED_WINDOW_MOTION_DETECTOR_TOP_ASSERT_SVH
`define CALIBRATED_WINDOW_MOTION_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define CWMD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("motion detector check failed");

// next-cycle implication, disabled while reset is high
`define CWMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("motion detector check failed");

`endif

// ----- rtl/core/cwmd_pkg.sv -----
// shared types and constants of the calibrated window motion detector
// no dependencies
`default_nettype none

package cwmd_pkg;

   localparam int SENS_WIDTH     = 15;
   localparam int CAL_WIDTH      = 10;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int NUM_LANES      = 3;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SENSITIVITY = CSR_ADDR_WIDTH'(0);
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_CAL_LENGTH  = CSR_ADDR_WIDTH'(1);

   localparam logic [SENS_WIDTH-1:0] SENS_RESET    = SENS_WIDTH'(64);
   localparam logic [CAL_WIDTH-1:0]  CAL_LEN_RESET = CAL_WIDTH'(100);

   // control shared by all lanes for one accepted sample
   typedef struct packed {
      logic learn;
      logic first;
   } lane_ctrl_type;

   // what the lanes found, handed to the merge stage
   typedef struct packed {
      logic                 load;
      logic                 calibrating;
      logic [NUM_LANES-1:0] moved;
   } merge_in_type;

endpackage

`default_nettype wire

// ----- rtl/core/cwmd_lane.sv -----
// one axis lane: running min/max during calibration, window compare after
// depends on cwmd_pkg
`default_nettype none

module cwmd_lane #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire cwmd_pkg::lane_ctrl_type          ctrl,
   input  wire logic signed [SAMPLE_WIDTH-1:0]   sample,
   input  wire logic [cwmd_pkg::SENS_WIDTH-1:0]  sensitivity,
   output logic                                  moved
);

   // wide enough for extreme plus or minus margin without overflow
   localparam int WIDE_W =
      ((SAMPLE_WIDTH > cwmd_pkg::SENS_WIDTH) ? SAMPLE_WIDTH : cwmd_pkg::SENS_WIDTH + 1) + 1;

   logic signed [SAMPLE_WIDTH-1:0] low_ff, low_in;
   logic signed [SAMPLE_WIDTH-1:0] high_ff, high_in;
   logic signed [WIDE_W-1:0]       sample_w, upper_w, lower_w, margin_w;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (ctrl.learn) begin
         if (ctrl.first || (sample < low_ff)) begin
            low_in = sample;
         end
         if (ctrl.first || (sample > high_ff)) begin
            high_in = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   always_comb begin
      sample_w = {{(WIDE_W-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};
      margin_w = {{(WIDE_W-cwmd_pkg::SENS_WIDTH){1'b0}}, sensitivity};
      upper_w  = {{(WIDE_W-SAMPLE_WIDTH){high_ff[SAMPLE_WIDTH-1]}}, high_ff} + margin_w;
      lower_w  = {{(WIDE_W-SAMPLE_WIDTH){low_ff[SAMPLE_WIDTH-1]}}, low_ff} - margin_w;
      moved    = (sample_w > upper_w) || (sample_w < lower_w);
   end

endmodule

`default_nettype wire

// ----- rtl/core/cwmd_merge.sv -----
// merge stage: combines lane flags into the alarm and holds the result register
// depends on cwmd_pkg
`default_nettype none

module cwmd_merge (
   input  wire                        clock,
   input  wire                        reset,
   input  wire cwmd_pkg::merge_in_type found,
   input  wire                        rsp_ready,
   output logic                       slot_free,
   output logic                       rsp_valid,
   output logic                       rsp_calibrating,
   output logic                       rsp_moved_x,
   output logic                       rsp_moved_y,
   output logic                       rsp_moved_z,
   output logic                       rsp_alarm
);

   logic                           valid_ff, valid_in;
   logic                           calibrating_ff;
   logic [cwmd_pkg::NUM_LANES-1:0] moved_ff, moved_in;
   logic                           alarm_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (found.load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
      // flags are meaningless while learning the window
      moved_in = found.calibrating ? '0 : found.moved;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (found.load) begin
         calibrating_ff <= found.calibrating;
         moved_ff       <= moved_in;
         alarm_ff       <= |moved_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_calibrating = calibrating_ff;
   assign rsp_moved_x     = moved_ff[0];
   assign rsp_moved_y     = moved_ff[1];
   assign rsp_moved_z     = moved_ff[2];
   assign rsp_alarm       = alarm_ff;

endmodule

`default_nettype wire

// ----- rtl/core/calibrated_window_motion_detector_top.sv -----
// top level of the calibrated window motion detector: registers, calibration
// control, three axis lanes and the merge stage; depends on cwmd_pkg,
// cwmd_lane and cwmd_merge
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_accel_x/y/z
//   rsp       out        rsp_valid/rsp_ready   rsp_calibrating, rsp_moved_x/y/z, rsp_alarm
//   csr       in         csr_valid/csr_ready   csr_index, csr_wdata
//
// one sample per cycle unless rsp stalls; a result lands in the merge stage's
// output register in the cycle after its transfer; all three lanes update
// min/max and compare the window on transfer. a sample is taken when the
// output register is empty or being emptied, so rsp stalls back up to req
// after one held result. reset is synchronous; no clearing pass is needed.
`default_nettype none

module calibrated_window_motion_detector_top #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0]      req_accel_x,
   input  wire logic signed [SAMPLE_WIDTH-1:0]      req_accel_y,
   input  wire logic signed [SAMPLE_WIDTH-1:0]      req_accel_z,
   output logic                                     rsp_valid,
   input  wire                                      rsp_ready,
   output logic                                     rsp_calibrating,
   output logic                                     rsp_moved_x,
   output logic                                     rsp_moved_y,
   output logic                                     rsp_moved_z,
   output logic                                     rsp_alarm,
   input  wire                                      csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cwmd_pkg::CSR_ADDR_WIDTH-1:0] csr_index,
   input  wire logic [cwmd_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   logic [cwmd_pkg::SENS_WIDTH-1:0] sens_ff, sens_in;
   logic [cwmd_pkg::CAL_WIDTH-1:0]  cal_len_ff, cal_len_in;
   logic [cwmd_pkg::CAL_WIDTH-1:0]  seen_ff, seen_in, seen_next, len_eff;
   logic                            calibrated_ff, calibrated_in;
   logic                            accept, slot_free;
   cwmd_pkg::lane_ctrl_type         lane_ctrl;
   cwmd_pkg::merge_in_type          found;
   logic [cwmd_pkg::NUM_LANES-1:0]  moved;

   assign csr_ready = 1'b1;
   assign req_ready = slot_free;
   assign accept    = req_valid && slot_free;

   always_comb begin
      sens_in    = sens_ff;
      cal_len_in = cal_len_ff;
      if (csr_valid) begin
         case (csr_index)
            cwmd_pkg::CSR_SENSITIVITY: sens_in    = csr_wdata[cwmd_pkg::SENS_WIDTH-1:0];
            cwmd_pkg::CSR_CAL_LENGTH:  cal_len_in = csr_wdata[cwmd_pkg::CAL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // zero length counts as one sample
      len_eff   = (cal_len_ff == '0) ? cwmd_pkg::CAL_WIDTH'(1) : cal_len_ff;
      seen_next = (seen_ff == '1) ? seen_ff : seen_ff + cwmd_pkg::CAL_WIDTH'(1);
      seen_in       = seen_ff;
      calibrated_in = calibrated_ff;
      if (accept && !calibrated_ff) begin
         seen_in = seen_next;
         if (seen_next >= len_eff) begin
            calibrated_in = 1'b1;
         end
      end
      lane_ctrl.learn = accept && !calibrated_ff;
      lane_ctrl.first = (seen_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff       <= cwmd_pkg::SENS_RESET;
         cal_len_ff    <= cwmd_pkg::CAL_LEN_RESET;
         seen_ff       <= '0;
         calibrated_ff <= 1'b0;
      end else begin
         sens_ff       <= sens_in;
         cal_len_ff    <= cal_len_in;
         seen_ff       <= seen_in;
         calibrated_ff <= calibrated_in;
      end
   end

   cwmd_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_x (
      .clock(clock), .reset(reset), .ctrl(lane_ctrl),
      .sample(req_accel_x), .sensitivity(sens_ff), .moved(moved[0])
   );

   cwmd_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_y (
      .clock(clock), .reset(reset), .ctrl(lane_ctrl),
      .sample(req_accel_y), .sensitivity(sens_ff), .moved(moved[1])
   );

   cwmd_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_z (
      .clock(clock), .reset(reset), .ctrl(lane_ctrl),
      .sample(req_accel_z), .sensitivity(sens_ff), .moved(moved[2])
   );

   always_comb begin
      found.load        = accept;
      found.calibrating = !calibrated_ff;
      found.moved       = moved;
   end

   cwmd_merge u_merge (
      .clock(clock),
      .reset(reset),
      .found(found),
      .rsp_ready(rsp_ready),
      .slot_free(slot_free),
      .rsp_valid(rsp_valid),
      .rsp_calibrating(rsp_calibrating),
      .rsp_moved_x(rsp_moved_x),
      .rsp_moved_y(rsp_moved_y),
      .rsp_moved_z(rsp_moved_z),
      .rsp_alarm(rsp_alarm)
   );

endmodule

`default_nettype wire

// ----- rtl/core/cwmd_checker.sv -----
// port-level checker for the motion detector, bound to the top level
// depends on calibrated_window_motion_detector_top_assert.svh
`default_nettype none
`include "calibrated_window_motion_detector_top_assert.svh"

module cwmd_port_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_ready,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire rsp_calibrating,
   input wire rsp_moved_x,
   input wire rsp_moved_y,
   input wire rsp_moved_z,
   input wire rsp_alarm
);

   logic       rsp_stall;
   logic [4:0] rsp_flags;
   logic       rsp_any_moved;
   logic       rsp_cal_result;
   logic       rsp_run_result;

   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign rsp_flags      = {rsp_calibrating, rsp_moved_x, rsp_moved_y, rsp_moved_z, rsp_alarm};
   assign rsp_any_moved  = rsp_alarm || rsp_moved_x || rsp_moved_y || rsp_moved_z;
   assign rsp_cal_result = rsp_valid && rsp_calibrating;
   assign rsp_run_result = rsp_valid && !rsp_calibrating;

   // a held result keeps its flags
   `CWMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_flags))

   // every sample transfer leaves a result behind
   `CWMD_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && req_ready, rsp_valid)

   // no motion flags while the window is being learned
   `CWMD_ASSERT_NOW(a_cal_quiet, clock, reset, rsp_cal_result, !rsp_any_moved)

   // once calibrated, never back to calibrating until reset
   `CWMD_ASSERT_NEXT(a_cal_done, clock, reset, rsp_run_result, !rsp_cal_result)

endmodule

bind calibrated_window_motion_detector_top cwmd_port_checker u_cwmd_checker (.*);

`default_nettype wire
